// ----- src/sbsh_pkg.sv -----
// Package for the SHA-256 byte stream hasher: payload types, controller
// command and status structs, initial hash values and round constants.
// No dependencies.
package sbsh_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Input action codes
  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  typedef struct packed {
    logic       absorb;     // write data byte at fill position
    logic       pad;        // write 0x80 and zero the tail, latch total length
    logic       len;        // write length words
    logic       len_clear;  // zero words 0..13 before the length block
    logic       init;       // load working variables from hash
    logic       round;      // run one round
    logic [5:0] round_idx;
    logic       fold;       // add working variables into hash
    logic       count_add;  // add 512 to bit count
    logic       clear_all;  // return to initial state after digest
    logic [2:0] word_idx;
  } cmd_t;

  typedef struct packed {
    logic fill_full;  // the next byte completes the block
    logic pad_two;    // padding needs a second block
  } stat_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ----- src/sha256_byte_stream_hasher_core.sv -----
// SHA-256 byte stream hasher: top level joining controller and datapath.
// Depends on sbsh_pkg, sbsh_ctrl, sbsh_dp.
//
// Usage: each input transaction carries action and data_byte. An absorb
// adds one byte, and the 64th byte of a block starts a compression (load,
// 64 rounds at one round per cycle through the single round unit, fold)
// during which in_ready is low. A finish pads the message and compresses
// one block, or two when 56 or more bytes are pending, and then presents
// the eight digest words on the output channel, word_index 0 first,
// last_word on the eighth. While the receiver stalls, the current word
// holds; no new input is taken until all eight words are delivered, after
// which the hash returns to the initial values. Reset (synchronous, rst
// high) empties the block buffer, zeroes the bit count and loads the
// initial hash values.
module sha256_byte_stream_hasher_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sbsh_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sbsh_pkg::out_item_t  out_data
);

  sbsh_pkg::cmd_t  cmd;
  sbsh_pkg::stat_t stat;
  logic [31:0]     digest_word;

  sbsh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sbsh_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (in_data.data_byte),
    .stat        (stat),
    .digest_word (digest_word)
  );

  // Drive output transaction fields
  assign out_data.digest_word = digest_word;
  assign out_data.word_index  = cmd.word_idx;
  assign out_data.last_word   = (cmd.word_idx == 3'd7);

endmodule

// ----- src/sbsh_dp.sv -----
// Datapath of the SHA-256 byte stream hasher: message window, working
// variables, hash words, fill and bit counters, one round unit.
// Depends on sbsh_pkg.
module sbsh_dp (
  input  logic              clk,
  input  logic              rst,
  input  sbsh_pkg::cmd_t    cmd,
  input  logic [7:0]        data_byte,
  output sbsh_pkg::stat_t   stat,
  output logic [31:0]       digest_word
);

  logic [31:0] win [16];
  logic [31:0] win_next [16];
  logic [31:0] vars [8];
  logic [31:0] hash [8];
  logic [5:0]  fill;
  logic [63:0] count;

  logic [31:0] w15, w2, g0, g1, w_new;
  logic [31:0] s0, s1, ch, mj, t1, t2;

  assign stat.fill_full = (fill == 6'd63);
  assign stat.pad_two   = (fill[5:3] == 3'b111);
  assign digest_word    = hash[cmd.word_idx];

  // Schedule expansion on fixed taps of the shifting window
  always_comb begin
    w15 = win[1];
    w2  = win[14];
    g0  = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
    g1  = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
    w_new = win[0] + g0 + win[9] + g1;
  end

  // Round function
  always_comb begin
    s1 = {vars[4][5:0], vars[4][31:6]} ^ {vars[4][10:0], vars[4][31:11]}
       ^ {vars[4][24:0], vars[4][31:25]};
    ch = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    t1 = vars[7] + s1 + ch + sbsh_pkg::RK[cmd.round_idx] + win[0];
    s0 = {vars[0][1:0], vars[0][31:2]} ^ {vars[0][12:0], vars[0][31:13]}
       ^ {vars[0][21:0], vars[0][31:22]};
    mj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t2 = s0 + mj;
  end

  // Window update: byte write, padding, length, or shift
  always_comb begin
    for (int w = 0; w < 16; w++) begin
      win_next[w] = win[w];
    end
    if (cmd.absorb) begin
      for (int w = 0; w < 16; w++) begin
        for (int b = 0; b < 4; b++) begin
          if (fill == 6'(w * 4 + b)) begin
            win_next[w][31 - 8 * b -: 8] = data_byte;
          end
        end
      end
    end else if (cmd.pad) begin
      for (int w = 0; w < 16; w++) begin
        for (int b = 0; b < 4; b++) begin
          if (fill == 6'(w * 4 + b)) begin
            win_next[w][31 - 8 * b -: 8] = 8'h80;
          end else if (6'(w * 4 + b) > fill) begin
            win_next[w][31 - 8 * b -: 8] = 8'h00;
          end
        end
      end
    end else if (cmd.len) begin
      if (cmd.len_clear) begin
        for (int w = 0; w < 14; w++) begin
          win_next[w] = 32'h0;
        end
      end
      win_next[14] = count[63:32];
      win_next[15] = count[31:0];
    end else if (cmd.round) begin
      for (int w = 0; w < 15; w++) begin
        win_next[w] = win[w + 1];
      end
      win_next[15] = w_new;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    for (int w = 0; w < 16; w++) begin
      win[w] <= win_next[w];
    end
    if (cmd.init) begin
      for (int i = 0; i < 8; i++) begin
        vars[i] <= hash[i];
      end
    end else if (cmd.round) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

  // Hash words, fill and bit count
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= sbsh_pkg::IV[i];
      end
      fill  <= 6'd0;
      count <= 64'd0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + vars[i];
        end
      end
      if (cmd.absorb) begin
        fill <= fill + 6'd1;
      end
      if (cmd.pad) begin
        count <= count + {55'd0, fill, 3'b000};
      end else if (cmd.count_add) begin
        count <= count + 64'd512;
      end
    end
  end

endmodule

// ----- src/sbsh_ctrl.sv -----
// Controller of the SHA-256 byte stream hasher: sequences absorb, padding,
// compression rounds and digest output. Depends on sbsh_pkg.
module sbsh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sbsh_pkg::stat_t   stat,
  output sbsh_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_LEN   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [1:0] M_ABS  = 2'd0;
  localparam logic [1:0] M_FIN1 = 2'd1;
  localparam logic [1:0] M_FIN2 = 2'd2;

  logic [2:0] state, state_next;
  logic [1:0] mode, mode_next;
  logic [5:0] round_idx, round_idx_next;
  logic [2:0] word_idx, word_idx_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // Next state and commands
  always_comb begin
    state_next     = state;
    mode_next      = mode;
    round_idx_next = round_idx;
    word_idx_next  = word_idx;
    cmd            = '0;
    cmd.round_idx  = round_idx;
    cmd.word_idx   = word_idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == sbsh_pkg::ACT_ABSORB) begin
            cmd.absorb = 1'b1;
            if (stat.fill_full) begin
              mode_next  = M_ABS;
              state_next = S_INIT;
            end
          end else begin
            cmd.pad = 1'b1;
            if (stat.pad_two) begin
              mode_next  = M_FIN1;
              state_next = S_INIT;
            end else begin
              mode_next  = M_FIN2;
              state_next = S_LEN;
            end
          end
        end
      end
      S_INIT: begin
        cmd.init       = 1'b1;
        round_idx_next = 6'd0;
        state_next     = S_ROUND;
      end
      S_ROUND: begin
        cmd.round      = 1'b1;
        round_idx_next = round_idx + 6'd1;
        if (round_idx == 6'd63) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        unique case (mode)
          M_ABS: begin
            cmd.count_add = 1'b1;
            state_next    = S_IDLE;
          end
          M_FIN1: begin
            state_next = S_LEN;
          end
          default: begin
            word_idx_next = 3'd0;
            state_next    = S_OUT;
          end
        endcase
      end
      S_LEN: begin
        cmd.len       = 1'b1;
        cmd.len_clear = (mode == M_FIN1);
        mode_next     = M_FIN2;
        state_next    = S_INIT;
      end
      S_OUT: begin
        if (out_ready) begin
          word_idx_next = word_idx + 3'd1;
          if (word_idx == 3'd7) begin
            cmd.clear_all = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= M_ABS;
      round_idx <= 6'd0;
      word_idx  <= 3'd0;
    end else begin
      state     <= state_next;
      mode      <= mode_next;
      round_idx <= round_idx_next;
      word_idx  <= word_idx_next;
    end
  end

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && round_idx == 6'd63) |=> (state == S_FOLD))
    else $error("compression did not fold after last round");

  a_last_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && word_idx == 3'd7) |=> (state == S_IDLE))
    else $error("block not idle after last digest word");

  a_out_start: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (word_idx == 3'd0 && mode == M_FIN2))
    else $error("digest output started out of sequence");

endmodule

// ----- tb/sv/tb_sha256_byte_stream_hasher_core.sv -----
// Testbench for sha256_byte_stream_hasher_core: drives absorb and finish
// transactions and checks every digest word against a SHA-256 predictor.
// Depends on sbsh_pkg and the hasher RTL.

class digest_scoreboard;
  sbsh_pkg::out_item_t pending_words[$];
  logic [7:0]  msg_block [64];
  int unsigned fill_level;
  logic [63:0] bit_total;
  logic [31:0] chain [8];
  int unsigned mismatches;

  function void clear_message();
    fill_level = 0;
    bit_total  = '0;
    for (int i = 0; i < 8; i++) chain[i] = sbsh_pkg::IV[i];
  endfunction

  function new();
    mismatches = 0;
    clear_message();
  endfunction

  function logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run one 64-round compression of msg_block into the chain value.
  function void compress();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wr, t1, t2, s0, s1, g0, g1;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        g0 = rotr(w[(r-15)&15], 7) ^ rotr(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
        g1 = rotr(w[(r-2)&15], 17) ^ rotr(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
        wr = w[r&15] + g0 + w[(r-7)&15] + g1;
        w[r&15] = wr;
      end
      s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sbsh_pkg::RK[r] + wr;
      s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endfunction

  // Note an accepted input transaction; a finish queues eight digest words.
  function void note_input(sbsh_pkg::in_item_t it);
    logic [63:0] total;
    sbsh_pkg::out_item_t o;
    if (it.action == sbsh_pkg::ACT_ABSORB) begin
      msg_block[fill_level] = it.data_byte;
      fill_level++;
      if (fill_level == 64) begin
        compress();
        bit_total += 64'd512;
        fill_level = 0;
      end
    end else begin
      total = bit_total + 64'(fill_level * 8);
      msg_block[fill_level] = 8'h80;
      for (int i = fill_level + 1; i < 64; i++) msg_block[i] = 8'h00;
      if (fill_level >= 56) begin
        compress();
        for (int i = 0; i < 56; i++) msg_block[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) msg_block[56+i] = total[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = chain[i];
        o.word_index  = 3'(i);
        o.last_word   = (i == 7);
        pending_words.push_back(o);
      end
      clear_message();
    end
  endfunction

  // Check one accepted digest word against the oldest expectation.
  function void check_word(sbsh_pkg::out_item_t got);
    sbsh_pkg::out_item_t exp_w;
    if (pending_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected digest word %h", got);
      return;
    end
    exp_w = pending_words.pop_front();
    if (got !== exp_w) begin
      mismatches++;
      if (mismatches <= 10)
        $display("digest mismatch: exp word %h idx %0d last %0b, got word %h idx %0d last %0b",
                 exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                 got.digest_word, got.word_index, got.last_word);
    end
  endfunction
endclass

module tb_sha256_byte_stream_hasher_core;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  sbsh_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  sbsh_pkg::out_item_t out_data;

  digest_scoreboard sb = new();
  longint unsigned cycle_count = 0;
  bit        idle_off = 1'b0;
  bit        hold_off_rx = 1'b0;

  sha256_byte_stream_hasher_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // Note accepted transactions on both channels.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && in_valid && in_ready) sb.note_input(in_data);
    if (!rst && out_valid && out_ready) sb.check_word(out_data);
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycle_count > 2000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls in bursts, or a long hold when asked.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (hold_off_rx) begin
        out_ready <= 1'b0;
        for (int i = 0; i < 600; i++) @(posedge clk);
        hold_off_rx = 1'b0;
      end else if (!idle_off && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 19);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one transaction and hold it until accepted, with random gaps before.
  task automatic send_item(logic act, logic [7:0] b);
    if (!idle_off && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{action: act, data_byte: b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_item(sbsh_pkg::ACT_ABSORB, 8'($urandom));
    send_item(sbsh_pkg::ACT_FINISH, 8'($urandom));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int len;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty message, finish with junk byte, extreme bytes,
    // padding boundaries at 55, 56 and 64 bytes.
    send_item(sbsh_pkg::ACT_FINISH, 8'hff);
    send_item(sbsh_pkg::ACT_ABSORB, 8'h00);
    send_item(sbsh_pkg::ACT_ABSORB, 8'hff);
    send_item(sbsh_pkg::ACT_ABSORB, 8'h80);
    send_item(sbsh_pkg::ACT_FINISH, 8'h00);
    send_message(55);
    send_message(56);
    drain_results();
    send_message(64);

    // Long receiver hold while the sender keeps offering.
    hold_off_rx = 1'b1;
    send_message(3);
    send_message(2);
    send_message(1);

    // Random messages, mostly short, a few over one block.
    sent = 0;
    while (sent < 210) begin
      if (sent > 150) idle_off = 1'b1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 130) : $urandom_range(0, 20);
      send_message(len);
      sent += len + 1;
      if ($urandom_range(0, 15) == 0) drain_results();
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
src/sbsh_pkg.sv
src/sbsh_dp.sv
src/sbsh_ctrl.sv
src/sha256_byte_stream_hasher_core.sv
tb/sv/tb_sha256_byte_stream_hasher_core.sv
